### sv/polyphase_oversampling_interpolator_defines.svh
// ----------------------------------------------------------------------------
// polyphase oversampling interpolator assertion macros
// concurrent checks clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef POLYPHASE_OVERSAMPLING_INTERPOLATOR_DEFINES_SVH
`define POLYPHASE_OVERSAMPLING_INTERPOLATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define POI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define POI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define POI_ASSERT_IMP(lbl, ante, cons, msg)
`define POI_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### sv/poi_pkg.sv
// ----------------------------------------------------------------------------
// poi_pkg
// shared types and constants of the polyphase oversampling interpolator
// ----------------------------------------------------------------------------
package poi_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_W        = 18;
  localparam int COEF_FRAC     = 16;
  localparam int MAX_CHANNELS  = 2;
  localparam int CHAN_W        = 1;
  localparam int MAX_PHASES    = 16;
  localparam int PHASE_W       = 4;
  localparam int SHORT_TAPS    = 12;
  localparam int LONG_TAPS_DEF = 64;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;

  // mode codes
  localparam logic [1:0] MODE_SHORT4 = 2'd0;
  localparam logic [1:0] MODE_LONG8  = 2'd1;
  localparam logic [1:0] MODE_LONG16 = 2'd2;
  localparam logic [1:0] MODE_LONG4  = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0]            phase_index;
    logic [CHAN_W-1:0]             channel_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last;
  } out_item_t;

  // per-tap control that travels down each lane
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } lane_ctl_t;

  // hand-off of one finished phase to the output stage
  typedef struct packed {
    logic               load;
    logic [PHASE_W-1:0] phase;
    logic               last_frame;
  } merge_load_t;

endpackage

### sv/polyphase_oversampling_interpolator.sv
// ----------------------------------------------------------------------------
// polyphase_oversampling_interpolator: one frame in, phases x 2 items out
// per phase: one shared tap counter sweeps both lanes at once
// reset: history clearing pass over LONG_TAPS entries, no frame taken until done
// ----------------------------------------------------------------------------
`include "polyphase_oversampling_interpolator_defines.svh"

module polyphase_oversampling_interpolator #(
  parameter int LONG_TAPS = poi_pkg::LONG_TAPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  poi_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output poi_pkg::out_item_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [poi_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [poi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import poi_pkg::*;

  localparam int PTR_W  = $clog2(LONG_TAPS);
  localparam int PTR_W1 = PTR_W + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_HAND  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [PTR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PTR_W-1:0]   tap_r, tap_nxt;
  logic [1:0]         mode_r;
  logic [1:0]         active_r;

  logic               in_acc;
  logic               use_long;
  logic [PTR_W-1:0]   last_tap;
  logic [PHASE_W-1:0] last_phase;
  logic [PHASE_W-1:0] rom_row;
  logic [PTR_W1-1:0]  pos_raw;
  logic [PTR_W-1:0]   rd_addr;
  logic               hist_we;
  logic [PTR_W-1:0]   hist_waddr;

  lane_ctl_t          lane_ctl;
  merge_load_t        merge_ld;
  coef_t              coef;
  logic               merge_busy;
  logic [MAX_CHANNELS-1:0] lane_done;
  sample_t            lane_value [MAX_CHANNELS];
  sample_t            lane_wdata [MAX_CHANNELS];
  sample_t            frame_smp [MAX_CHANNELS];

  assign in_acc   = in_valid && in_ready;
  assign in_ready = state_r == ST_IDLE;
  assign use_long = mode_r != MODE_SHORT4;
  assign last_tap = use_long ? PTR_W'(LONG_TAPS - 1) : PTR_W'(SHORT_TAPS - 1);

  // phase count and long-table row stride per mode
  always_comb begin
    unique case (mode_r)
      MODE_SHORT4: begin
        last_phase = PHASE_W'(3);
        rom_row    = phase_r;
      end
      MODE_LONG8: begin
        last_phase = PHASE_W'(7);
        rom_row    = {phase_r[PHASE_W-2:0], 1'b0};
      end
      MODE_LONG16: begin
        last_phase = PHASE_W'(15);
        rom_row    = phase_r;
      end
      MODE_LONG4: begin
        last_phase = PHASE_W'(3);
        rom_row    = {phase_r[PHASE_W-3:0], 2'b00};
      end
      default: begin
        last_phase = PHASE_W'(3);
        rom_row    = phase_r;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SHORT4;
      active_r <= 2'd2;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_MODE:   mode_r   <= cfg_wdata;
        CFG_ACTIVE: active_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer: clear, take frame, sweep taps per phase, hand off
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    wp_nxt      = wp_r;
    phase_nxt   = phase_r;
    tap_nxt     = tap_r;
    merge_ld    = '0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + PTR_W'(1);
        if (clr_cnt_r == PTR_W'(LONG_TAPS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          wp_nxt    = (wp_r == PTR_W'(LONG_TAPS - 1)) ? '0 : wp_r + PTR_W'(1);
          phase_nxt = '0;
          tap_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tap_r == last_tap) begin
          tap_nxt   = '0;
          state_nxt = ST_WAIT;
        end else begin
          tap_nxt = tap_r + PTR_W'(1);
        end
      end
      ST_WAIT: begin
        if (&lane_done) state_nxt = ST_HAND;
      end
      ST_HAND: begin
        if (!merge_busy) begin
          merge_ld.load       = 1'b1;
          merge_ld.phase      = phase_r;
          merge_ld.last_frame = phase_r == last_phase;
          if (phase_r == last_phase) begin
            state_nxt = ST_IDLE;
          end else begin
            phase_nxt = phase_r + PHASE_W'(1);
            state_nxt = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      wp_r      <= '0;
      phase_r   <= '0;
      tap_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      wp_r      <= wp_nxt;
      phase_r   <= phase_nxt;
      tap_r     <= tap_nxt;
    end
  end

  // ring position of tap t: newest frame sits one behind the write pointer
  assign pos_raw = {1'b0, wp_r} - PTR_W1'(1) - {1'b0, tap_r};
  assign rd_addr = pos_raw[PTR_W] ? PTR_W'(pos_raw + PTR_W1'(LONG_TAPS))
                                  : pos_raw[PTR_W-1:0];

  always_comb begin
    lane_ctl.vld   = state_r == ST_RUN;
    lane_ctl.first = tap_r == '0;
    lane_ctl.last  = tap_r == last_tap;
  end

  assign hist_we    = (state_r == ST_CLEAR) || in_acc;
  assign hist_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : wp_r;

  assign frame_smp[0] = in_data.sample_left;
  assign frame_smp[1] = in_data.sample_right;

  poi_coef_rom #(
    .LONG_TAPS (LONG_TAPS)
  ) u_rom (
    .clk        (clk),
    .use_long_i (use_long),
    .row_i      (rom_row),
    .tap_i      (tap_r),
    .coef_o     (coef)
  );

  // channel lanes share the tap sequence and coefficient
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    assign lane_wdata[c] = (state_r == ST_IDLE && 2'(c) < active_r) ? frame_smp[c] : '0;

    poi_lane #(
      .LONG_TAPS (LONG_TAPS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en_i   (hist_we),
      .wr_addr_i (hist_waddr),
      .wr_data_i (lane_wdata[c]),
      .rd_addr_i (rd_addr),
      .ctl_i     (lane_ctl),
      .coef_i    (coef),
      .done_o    (lane_done[c]),
      .value_o   (lane_value[c])
    );
  end

  poi_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (merge_ld),
    .value_i   (lane_value),
    .busy_o    (merge_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `POI_ASSERT_NXT(a_accept_starts_run, in_acc, state_r == ST_RUN, "frame accept did not start a phase sweep")
  `POI_ASSERT_IMP(a_load_when_free, merge_ld.load, !merge_busy, "phase handed off over a pending phase")
  `POI_ASSERT_IMP(a_done_in_wait, lane_done[0], state_r == ST_WAIT, "lane finished outside the wait state")
  `POI_ASSERT_IMP(a_last_on_end_chan, out_valid && out_data.last, out_data.channel_index == CHAN_W'(MAX_CHANNELS - 1), "last flag on a channel other than the final one")

endmodule

### sv/poi_coef_rom.sv
// ----------------------------------------------------------------------------
// poi_coef_rom
// coefficient store: fixed 4-phase short table and the windowed-sinc long
// table, built at elaboration; one registered read per cycle
// ----------------------------------------------------------------------------
module poi_coef_rom #(
  parameter int LONG_TAPS = poi_pkg::LONG_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          use_long_i,
  input  logic [poi_pkg::PHASE_W-1:0]   row_i,
  input  logic [$clog2(LONG_TAPS)-1:0]  tap_i,
  output poi_pkg::coef_t                coef_o
);
  import poi_pkg::*;

  localparam int PTR_W     = $clog2(LONG_TAPS);
  localparam int ROM_DEPTH = MAX_PHASES * LONG_TAPS;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);
  localparam int SHORT_AW  = $clog2(SHORT_TAPS);

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint WIN_A   = 64'sd450971566;
  localparam longint WIN_C   = 64'sd85899346;
  localparam longint HALF    = longint'(MAX_PHASES) * LONG_TAPS / 2;
  localparam longint QUARTER = HALF / 2;
  localparam longint EIGHTH  = HALF / 4;
  localparam longint SCALE   = 64'sd65536;

  typedef coef_t long_rom_t [ROM_DEPTH];
  typedef coef_t short_row_t [SHORT_TAPS];
  typedef short_row_t short_tab_t [4];

  localparam short_tab_t SHORT_TAB = '{
    '{ 18'sd112,   18'sd720,  -18'sd1288,  18'sd2176,  -18'sd3896,   18'sd9000,
       18'sd63712, -18'sd6704, 18'sd3120, -18'sd1744,   18'sd976,   -18'sd544 },
    '{-18'sd1912,  18'sd1920, -18'sd3392,  18'sd5840, -18'sd10912,  18'sd30480,
       18'sd51104, -18'sd13128, 18'sd6656, -18'sd3816,  18'sd2168,  -18'sd1240 },
    '{-18'sd1240,  18'sd2168, -18'sd3816,  18'sd6656, -18'sd13128,  18'sd51104,
       18'sd30480, -18'sd10912, 18'sd5840, -18'sd3392,  18'sd1920,  -18'sd1912 },
    '{-18'sd544,   18'sd976,  -18'sd1744,  18'sd3120,  -18'sd6704,  18'sd63712,
       18'sd9000,  -18'sd3896, 18'sd2176, -18'sd1288,   18'sd720,    18'sd112 }
  };

  // long division, one quotient bit per step
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    int i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // signed quotient truncated toward zero
  function automatic longint sdiv(input longint num, input longint den);
    longint unsigned un;
    longint unsigned ud;
    longint unsigned q;
    logic neg;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? longint'(-num) : num;
    ud  = (den < 0) ? longint'(-den) : den;
    q   = udiv(un, ud);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // sin(pi * num / den) in Q30, num >= 0
  function automatic longint sin_pi(input longint num, input longint den);
    longint unsigned two_den;
    longint a;
    longint x;
    longint x2;
    longint t;
    longint s;
    logic neg;
    int k;
    two_den = 2 * den;
    a   = $signed(longint'(num) - $signed(udiv(num, two_den) * two_den));
    neg = 1'b0;
    if (a >= den) begin
      a   = a - den;
      neg = 1'b1;
    end
    if (2 * a > den) a = den - a;
    x  = $signed(udiv(PI_Q30 * a, den));
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (k = 7; k >= 1; k--) begin
      t = Q30_ONE - $signed(udiv((x2 * t) >> 30, longint'((2 * k) * (2 * k + 1))));
    end
    s = (x * t) >> 30;
    return neg ? -s : s;
  endfunction

  // Q30 product, magnitude truncated
  function automatic longint mul_q30(input longint a, input longint b);
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned r;
    logic neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? longint'(-a) : a;
    ub  = (b < 0) ? longint'(-b) : b;
    r   = (ua * ub) >> 30;
    return neg ? -$signed(r) : $signed(r);
  endfunction

  // quotient rounded to nearest, ties away from zero
  function automatic longint div_round(input longint num, input longint den);
    longint unsigned un;
    longint unsigned ud;
    longint unsigned q;
    logic neg;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? longint'(-num) : num;
    ud  = (den < 0) ? longint'(-den) : den;
    q   = udiv(2 * un + ud, 2 * ud);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // blackman-windowed sinc rows, each normalized to unity sum
  function automatic long_rom_t build_long_rom();
    long_rom_t rom;
    longint raw [LONG_TAPS];
    longint sum;
    longint dn;
    longint ad;
    longint sinc;
    longint win;
    longint pd;
    int p;
    int tp;
    for (p = 0; p < MAX_PHASES; p++) begin
      sum = 0;
      for (tp = 0; tp < LONG_TAPS; tp++) begin
        dn = longint'(tp) * MAX_PHASES - longint'(LONG_TAPS / 2 - 1) * MAX_PHASES + p;
        ad = (dn < 0) ? -dn : dn;
        if (ad == 0) begin
          sinc = Q30_ONE;
        end else begin
          pd   = $signed(udiv(PI_Q30 * ad, MAX_PHASES));
          sinc = sdiv(sin_pi(ad, MAX_PHASES) * Q30_ONE, pd);
        end
        if (ad > HALF) begin
          win = 0;
        end else begin
          win = WIN_A + sdiv(sin_pi(ad + QUARTER, HALF), 2)
              + mul_q30(WIN_C, sin_pi(ad + EIGHTH, QUARTER));
        end
        raw[tp] = mul_q30(sinc, win);
        sum     = sum + raw[tp];
      end
      if (sum == 0) sum = Q30_ONE;
      for (tp = 0; tp < LONG_TAPS; tp++) begin
        rom[p * LONG_TAPS + tp] = COEF_W'(div_round(raw[tp] * SCALE, sum));
      end
    end
    return rom;
  endfunction

  localparam long_rom_t LONG_ROM = build_long_rom();

  logic [ROM_AW-1:0] long_addr;

  assign long_addr = ROM_AW'(row_i) * ROM_AW'(LONG_TAPS) + ROM_AW'(tap_i);

  // registered coefficient read
  always_ff @(posedge clk) begin
    if (use_long_i) begin
      coef_o <= LONG_ROM[long_addr];
    end else if (tap_i < PTR_W'(SHORT_TAPS)) begin
      coef_o <= SHORT_TAB[row_i[1:0]][tap_i[SHORT_AW-1:0]];
    end else begin
      coef_o <= '0;
    end
  end

endmodule

### sv/poi_lane.sv
// ----------------------------------------------------------------------------
// poi_lane
// one channel: sample history ring and a multiply-accumulate pipe with
// rounding and saturation of the phase sum
// ----------------------------------------------------------------------------
module poi_lane #(
  parameter int LONG_TAPS = poi_pkg::LONG_TAPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en_i,
  input  logic [$clog2(LONG_TAPS)-1:0]  wr_addr_i,
  input  poi_pkg::sample_t              wr_data_i,
  input  logic [$clog2(LONG_TAPS)-1:0]  rd_addr_i,
  input  poi_pkg::lane_ctl_t            ctl_i,
  input  poi_pkg::coef_t                coef_i,
  output logic                          done_o,
  output poi_pkg::sample_t              value_o
);
  import poi_pkg::*;

  localparam int PTR_W  = $clog2(LONG_TAPS);
  localparam int PROD_W = COEF_W + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + PTR_W;
  localparam int SH_W   = ACC_W - COEF_FRAC;

  sample_t hist_mem [LONG_TAPS];
  sample_t rd_data_r;

  lane_ctl_t s1_r;
  lane_ctl_t s2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     done_r;

  logic signed [ACC_W-1:0]  rnd;
  logic signed [SH_W-1:0]   shifted;
  logic [SH_W-SAMPLE_BITS:0] top_bits;

  // history ring
  always_ff @(posedge clk) begin
    if (wr_en_i) hist_mem[wr_addr_i] <= wr_data_i;
    rd_data_r <= hist_mem[rd_addr_i];
  end

  // control pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= ctl_i;
      s2_r   <= s1_r;
      done_r <= s2_r.vld && s2_r.last;
    end
  end

  // multiply, then accumulate
  always_ff @(posedge clk) begin
    prod_r <= coef_i * rd_data_r;
    if (s2_r.vld) begin
      if (s2_r.first) acc_r <= ACC_W'(prod_r);
      else            acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half away from zero, then saturate
  always_comb begin
    rnd      = acc_r + (acc_r[ACC_W-1] ? ACC_W'((1 << (COEF_FRAC - 1)) - 1)
                                       : ACC_W'(1 << (COEF_FRAC - 1)));
    shifted  = rnd[ACC_W-1:COEF_FRAC];
    top_bits = shifted[SH_W-1:SAMPLE_BITS-1];
    if ((&top_bits) || !(|top_bits)) begin
      value_o = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[SH_W-1]) begin
      value_o = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      value_o = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign done_o = done_r;

endmodule

### sv/poi_merge.sv
// ----------------------------------------------------------------------------
// poi_merge
// output stage: takes the lane results of one phase and sends them out one
// item per channel
// ----------------------------------------------------------------------------
module poi_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  poi_pkg::merge_load_t     load_i,
  input  poi_pkg::sample_t         value_i [poi_pkg::MAX_CHANNELS],
  output logic                     busy_o,
  output logic                     out_valid,
  input  logic                     out_ready,
  output poi_pkg::out_item_t       out_data
);
  import poi_pkg::*;

  logic               busy_r;
  logic [CHAN_W-1:0]  chan_r;
  logic [PHASE_W-1:0] phase_r;
  logic               last_frame_r;
  sample_t            val_r [MAX_CHANNELS];
  logic               chan_end;

  assign chan_end = chan_r == CHAN_W'(MAX_CHANNELS - 1);

  // control: busy from load until the last channel is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      chan_r <= '0;
    end else if (load_i.load) begin
      busy_r <= 1'b1;
      chan_r <= '0;
    end else if (busy_r && out_ready) begin
      if (chan_end) busy_r <= 1'b0;
      chan_r <= chan_end ? '0 : chan_r + CHAN_W'(1);
    end
  end

  // held results of the phase
  always_ff @(posedge clk) begin
    if (load_i.load) begin
      phase_r      <= load_i.phase;
      last_frame_r <= load_i.last_frame;
      val_r        <= value_i;
    end
  end

  assign busy_o    = busy_r;
  assign out_valid = busy_r;

  always_comb begin
    out_data.phase_index   = phase_r;
    out_data.channel_index = chan_r;
    out_data.value         = val_r[chan_r];
    out_data.last          = last_frame_r && chan_end;
  end

endmodule

### bench/poi_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_frame_checker
// watches the frame, result and register ports of the interpolator, computes
// the phase-major outputs of every accepted frame and compares them in order
// ----------------------------------------------------------------------------
module poi_frame_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  poi_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  poi_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [poi_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [poi_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             error_count,
  output int                             outstanding,
  output int                             compared
);
  import poi_pkg::*;

  localparam int     RING    = LONG_TAPS_DEF;
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint WIN_A   = 64'sd450971566;
  localparam longint WIN_C   = 64'sd85899346;
  localparam longint HALF    = MAX_PHASES * RING / 2;
  localparam longint SAT_HI  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO  = -SAT_HI - 1;

  // fixed 4-phase table, Q2.16
  int short_coef [4][SHORT_TAPS] = '{
    '{  112,   720, -1288,  2176,  -3896,  9000, 63712,  -6704,  3120, -1744,   976,  -544},
    '{-1912,  1920, -3392,  5840, -10912, 30480, 51104, -13128,  6656, -3816,  2168, -1240},
    '{-1240,  2168, -3816,  6656, -13128, 51104, 30480, -10912,  5840, -3392,  1920, -1912},
    '{ -544,   976, -1744,  3120,  -6704, 63712,  9000,  -3896,  2176, -1288,   720,   112}
  };

  int         long_coef [MAX_PHASES][RING];
  longint     history [MAX_CHANNELS][RING];
  logic [5:0] wr_slot;
  logic [1:0] mode_reg;
  logic [1:0] active_reg;
  out_item_t  expected_q [$];
  out_item_t  want;
  int         errors;
  int         checked;

  // sin(pi * num / den) in Q30
  function automatic longint sine_q30(input longint num, input longint den);
    longint a, x, x2, t, s;
    bit     neg;
    int     k;
    a = num % (2 * den);
    neg = 1'b0;
    if (a < 0) a += 2 * den;
    if (a >= den) begin
      a -= den;
      neg = 1'b1;
    end
    if (2 * a > den) a = den - a;
    x = (PI_Q30 * a) / den;
    x2 = (x * x) >>> 30;
    t = Q30_ONE;
    for (k = 7; k >= 1; k--)
      t = Q30_ONE - ((x2 * t) >>> 30) / (2 * k * (2 * k + 1));
    s = (x * t) >>> 30;
    return neg ? -s : s;
  endfunction

  // Q30 product truncated toward zero
  function automatic longint mul_q30(input longint a, input longint b);
    longint ua, ub, r;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    r = (ua * ub) >>> 30;
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // divide to nearest, ties away from zero
  function automatic longint round_div(input longint n, input longint d);
    longint un, ud, q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = (2 * un + ud) / (2 * ud);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  // windowed-sinc rows, each normalized to unity gain
  function automatic void build_long_coef();
    longint raw [RING];
    longint sum, dn, ad, sinc, win, pd;
    int     p, t;
    for (p = 0; p < MAX_PHASES; p++) begin
      sum = 0;
      for (t = 0; t < RING; t++) begin
        dn = longint'(t) * MAX_PHASES - longint'(RING / 2 - 1) * MAX_PHASES + p;
        ad = (dn < 0) ? -dn : dn;
        if (ad == 0) begin
          sinc = Q30_ONE;
        end else begin
          pd = (PI_Q30 * ad) / MAX_PHASES;
          sinc = (sine_q30(ad, MAX_PHASES) * Q30_ONE) / pd;
        end
        if (ad > HALF) win = 0;
        else win = WIN_A + sine_q30(ad + HALF / 2, HALF) / 2
                   + mul_q30(WIN_C, sine_q30(ad + HALF / 4, HALF / 2));
        raw[t] = mul_q30(sinc, win);
        sum += raw[t];
      end
      if (sum == 0) sum = Q30_ONE;
      for (t = 0; t < RING; t++)
        long_coef[p][t] = int'(round_div(raw[t] * 65536, sum));
    end
  endfunction

  // store one frame and queue every phase/channel output it causes
  function automatic void interpolate_frame(input in_item_t f);
    int        phases, stride, taps, total, n, p, c, t, pos, coef;
    longint    acc, r;
    out_item_t e;
    for (c = 0; c < MAX_CHANNELS; c++) begin
      acc = 0;
      if (c < active_reg) acc = (c == 0) ? f.sample_left : f.sample_right;
      history[c][wr_slot] = acc;
    end
    wr_slot = wr_slot + 6'd1;
    case (mode_reg)
      MODE_LONG8:  phases = 8;
      MODE_LONG16: phases = 16;
      default:     phases = 4;
    endcase
    stride = MAX_PHASES / phases;
    taps = (mode_reg == MODE_SHORT4) ? SHORT_TAPS : RING;
    total = phases * MAX_CHANNELS;
    n = 0;
    for (p = 0; p < phases; p++) begin
      for (c = 0; c < MAX_CHANNELS; c++) begin
        acc = 0;
        for (t = 0; t < taps; t++) begin
          pos = (int'(wr_slot) + 2 * RING - 1 - t) % RING;
          coef = (mode_reg == MODE_SHORT4) ? short_coef[p % 4][t]
                                           : long_coef[(p * stride) % MAX_PHASES][t];
          acc += longint'(coef) * history[c][pos];
        end
        r = round_div(acc, 65536);
        if (r > SAT_HI) r = SAT_HI;
        if (r < SAT_LO) r = SAT_LO;
        e.phase_index   = p[PHASE_W-1:0];
        e.channel_index = c[CHAN_W-1:0];
        e.value         = r[SAMPLE_BITS-1:0];
        e.last          = (n == total - 1);
        expected_q.push_back(e);
        n++;
      end
    end
  endfunction

  task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    build_long_coef();
    mode_reg = MODE_SHORT4;
    active_reg = 2'd2;
    wr_slot = '0;
    errors = 0;
    checked = 0;
  end

  // follow registers, predict on frame accept, compare on result accept
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (history[i, j]) history[i][j] = 0;
      wr_slot = '0;
      mode_reg = MODE_SHORT4;
      active_reg = 2'd2;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_MODE:   mode_reg = cfg_wdata;
          CFG_ACTIVE: active_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) interpolate_frame(in_data);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output item, phase %0d channel %0d value %0d",
                   $time, out_data.phase_index, out_data.channel_index, out_data.value);
        end else begin
          want = expected_q.pop_front();
          compare_field("phase_index", want.phase_index, out_data.phase_index);
          compare_field("channel_index", want.channel_index, out_data.channel_index);
          compare_field("value", want.value, out_data.value);
          compare_field("last", want.last, out_data.last);
          checked++;
        end
      end
    end
    outstanding <= expected_q.size();
    error_count <= errors;
    compared <= checked;
  end

endmodule

### bench/tb_polyphase_oversampling_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyphase_oversampling_interpolator
// drives stereo frames through every mode and channel count, with bursty
// input, varied output back-pressure and one long output hold-off; the frame
// checker predicts and compares every interpolated output
// ----------------------------------------------------------------------------
module tb_polyphase_oversampling_interpolator;
  import poi_pkg::*;

  localparam int FRAME_TARGET    = 220;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int IDLE_LIMIT      = 20000;
  localparam int DRAIN_CYCLES    = LONG_TAPS_DEF + 16;
  localparam int HOLD_PHASE      = 4;

  // register indexes past the defined pair, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam sample_t FULL_POS = 24'sh7FFFFF;
  localparam sample_t FULL_NEG = 24'sh800000;
  // taps of the first short-table row with a positive coefficient
  localparam bit [SHORT_TAPS-1:0] ROW0_POSITIVE = 12'b010101101011;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_RUNS} rx_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int        fail_total;
  int        pending;
  int        checked;
  int        frames_sent = 0;
  int        phase_count = 0;
  int        idle_cycles = 0;
  rx_style_t rx_style = RX_ALWAYS;
  bit        hold_req = 1'b0;
  bit        tx_gaps = 1'b0;
  int        burst_left = 0;
  int        stall_left = 0;
  int        run_left = 0;
  int        rx_tick = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  polyphase_oversampling_interpolator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  poi_frame_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .error_count (fail_total),
    .outstanding (pending),
    .compared    (checked)
  );

  // output back-pressure, with one long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_OFF_CYCLES;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: begin
          rx_tick++;
          out_ready <= (rx_tick % 3 != 0);
        end
        default: begin
          if (run_left > 0) begin
            run_left--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 15) == 0) run_left = $urandom_range(4, 40);
          end
        end
      endcase
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // offer one frame, then maybe drop valid for a gap between bursts
  task automatic send_frame(input sample_t left, input sample_t right);
    in_valid <= 1'b1;
    in_data <= {left, right};
    do @(posedge clk); while (!in_ready);
    frames_sent++;
    if (tx_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        burst_left = $urandom_range(0, 7);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2:       return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      3:       return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    int t;
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rounding ties on an empty history, both signs
    send_frame(24'sd2048, -24'sd2048);
    // full-scale run matched to the first short row: left clips high, right low
    for (t = SHORT_TAPS - 1; t >= 0; t--)
      send_frame(ROW0_POSITIVE[t] ? FULL_POS : FULL_NEG, ROW0_POSITIVE[t] ? FULL_NEG : FULL_POS);
    wait_drained();

    // long-table modes
    cfg_write(CFG_MODE, MODE_LONG8);
    send_frame(FULL_POS, FULL_NEG);
    wait_drained();
    cfg_write(CFG_MODE, MODE_LONG16);
    send_frame(pick_sample(), pick_sample());
    wait_drained();
    cfg_write(CFG_MODE, MODE_LONG4);
    send_frame(FULL_NEG, FULL_POS);
    wait_drained();

    // channel counts zero, one and three
    cfg_write(CFG_ACTIVE, 2'd0);
    send_frame(FULL_POS, FULL_POS);
    wait_drained();
    cfg_write(CFG_ACTIVE, 2'd1);
    send_frame(FULL_NEG, FULL_NEG);
    wait_drained();
    cfg_write(CFG_ACTIVE, 2'd3);
    send_frame(pick_sample(), pick_sample());
    wait_drained();

    // writes to spare indexes leave the settings alone
    cfg_write(CFG_SPARE_2, 2'd1);
    cfg_write(CFG_SPARE_3, 2'd0);
    send_frame(pick_sample(), pick_sample());
    wait_drained();

    // random register phases with random traffic shapes
    while (frames_sent < FRAME_TARGET) begin
      phase_count++;
      cfg_write(CFG_MODE, CFG_DATA_W'($urandom_range(0, 3)));
      cfg_write(CFG_ACTIVE, CFG_DATA_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 5) == 0)
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                  CFG_DATA_W'($urandom_range(0, 3)));
      rx_style = rx_style_t'($urandom_range(0, 3));
      tx_gaps = ($urandom_range(0, 2) != 0);
      burst_left = $urandom_range(0, 7);
      n = $urandom_range(4, 14);
      if (phase_count == HOLD_PHASE) begin
        // sender keeps offering while the output is held off
        rx_style = RX_ALWAYS;
        tx_gaps = 1'b0;
        n = 8;
        hold_req = 1'b1;
      end
      repeat (n) send_frame(pick_sample(), pick_sample());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d frames, %0d random register phases, %0d outputs compared",
             frames_sent, phase_count, checked);
    $display("summary: all four modes, channel counts 0 to 3, %0d-cycle output hold-off",
             HOLD_OFF_CYCLES);
    if (fail_total == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
